[hdl/olsu_pkg.sv]
// ----------------------------------------------------------------------------
// olsu_pkg
// Shared types and constants for the ordered list store unit.
// ----------------------------------------------------------------------------
package olsu_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    CMD_PREPEND = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_SEARCH  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic              prepend;
    logic              append;
    logic              remove;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

[hdl/olsu_cell.sv]
// ----------------------------------------------------------------------------
// olsu_cell
// One list slot: holds an entry, matches it against the request value and
// takes its neighbour's entry on a shift.
// ----------------------------------------------------------------------------
module olsu_cell (
  input  logic                       clk,
  input  olsu_pkg::cell_ctrl_t       ctrl,
  input  logic                       occupied,
  input  logic                       append_slot,
  input  logic [olsu_pkg::DATA_W-1:0] left_entry,
  input  logic [olsu_pkg::DATA_W-1:0] right_entry,
  input  logic                       found_in,
  output logic                       found_out,
  output logic [olsu_pkg::DATA_W-1:0] entry
);

  logic [olsu_pkg::DATA_W-1:0] entry_r;
  logic [olsu_pkg::DATA_W-1:0] entry_nxt;
  logic                        match;

  assign match     = occupied && (entry_r == ctrl.value);
  assign found_out = found_in | match;
  assign entry     = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.prepend) begin
      entry_nxt = left_entry;
    end else if (ctrl.append && append_slot) begin
      entry_nxt = ctrl.value;
    end else if (ctrl.remove && found_out) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[hdl/ordered_list_store_unit.sv]
// ----------------------------------------------------------------------------
// ordered_list_store_unit
// Bounded ordered list: prepend, append, remove first match, search.
// Cell row updates in the accept cycle; the status is held in pst_r and
// registered when the output is free; one request per cycle unless stalled.
// Reset: entry count and handshake state cleared; entry contents undefined.
// ----------------------------------------------------------------------------
module ordered_list_store_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic signed [31:0]          in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [4:0]                  out_count,
  output logic signed [31:0]          out_head_value,
  output logic signed [31:0]          out_tail_value
);

  localparam int N = olsu_pkg::CAPACITY;

  logic [olsu_pkg::CNT_W-1:0]  count_r;
  logic [olsu_pkg::CNT_W-1:0]  count_nxt;
  logic [olsu_pkg::CNT_W-1:0]  cnt_dec;
  logic [olsu_pkg::IDX_W-1:0]  tail_idx;
  logic                        pend_r;
  logic [1:0]                  pst_r;
  logic [1:0]                  status_nxt;
  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [olsu_pkg::COUNT_W-1:0] out_count_r;
  logic [olsu_pkg::DATA_W-1:0] out_head_r;
  logic [olsu_pkg::DATA_W-1:0] out_tail_r;
  logic                        accept;
  logic                        capture;
  logic                        full;
  logic                        any_found;
  olsu_pkg::cell_ctrl_t        ctrl;
  olsu_pkg::cmd_t              cmd;

  logic [olsu_pkg::DATA_W-1:0] entry_w [N];
  logic [N:0]                  found_w;

  assign cmd      = olsu_pkg::cmd_t'(in_cmd);
  assign full     = (count_r == olsu_pkg::CNT_W'(N));
  assign capture  = pend_r && (!out_valid_r || out_ready);
  assign in_ready = !pend_r || capture;
  assign accept   = in_valid && in_ready;

  assign found_w[0] = 1'b0;
  assign any_found  = found_w[N];

  always_comb begin
    ctrl.prepend = 1'b0;
    ctrl.append  = 1'b0;
    ctrl.remove  = 1'b0;
    ctrl.value   = in_value;
    count_nxt    = count_r;
    status_nxt   = olsu_pkg::ST_DONE;
    case (cmd)
      olsu_pkg::CMD_PREPEND: begin
        if (full) begin
          status_nxt = olsu_pkg::ST_FULL;
        end else begin
          ctrl.prepend = accept;
          count_nxt    = count_r + olsu_pkg::CNT_W'(1);
        end
      end
      olsu_pkg::CMD_APPEND: begin
        if (full) begin
          status_nxt = olsu_pkg::ST_FULL;
        end else begin
          ctrl.append = accept;
          count_nxt   = count_r + olsu_pkg::CNT_W'(1);
        end
      end
      olsu_pkg::CMD_REMOVE: begin
        ctrl.remove = accept;
        if (any_found) begin
          count_nxt = count_r - olsu_pkg::CNT_W'(1);
        end else begin
          status_nxt = olsu_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        if (!any_found) begin
          status_nxt = olsu_pkg::ST_NOT_FOUND;
        end
      end
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [olsu_pkg::DATA_W-1:0] left_in;
    logic [olsu_pkg::DATA_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = in_value;
    end else begin : g_mid
      assign left_in = entry_w[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_in = entry_w[i];
    end else begin : g_inner
      assign right_in = entry_w[i+1];
    end

    olsu_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (olsu_pkg::CNT_W'(i) < count_r),
      .append_slot (olsu_pkg::CNT_W'(i) == count_r),
      .left_entry  (left_in),
      .right_entry (right_in),
      .found_in    (found_w[i]),
      .found_out   (found_w[i+1]),
      .entry       (entry_w[i])
    );
  end

  assign cnt_dec  = count_r - olsu_pkg::CNT_W'(1);
  assign tail_idx = cnt_dec[olsu_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
        pst_r   <= status_nxt;
        pend_r  <= 1'b1;
      end else if (capture) begin
        pend_r  <= 1'b0;
      end
      if (capture) begin
        out_valid_r  <= 1'b1;
        out_status_r <= pst_r;
        out_count_r  <= olsu_pkg::COUNT_W'(count_r);
        if (count_r == '0) begin
          out_head_r <= '0;
          out_tail_r <= '0;
        end else begin
          out_head_r <= entry_w[0];
          out_tail_r <= entry_w[tail_idx];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;
  assign out_head_value = out_head_r;
  assign out_tail_value = out_tail_r;

endmodule
